FILE: src/vt100_lite_text_grid_top_macros.svh
// Assertion macros used by the checker file of the text grid terminal.
`ifndef VT100_LITE_TEXT_GRID_TOP_MACROS_SVH
`define VT100_LITE_TEXT_GRID_TOP_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define VTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define VTG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/vtg_pkg.sv
// Constants, codes and types of the text grid terminal.
package vtg_pkg;

  localparam int ROWS    = 25;
  localparam int COLS    = 80;
  localparam int CELLS   = ROWS * COLS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS + 1);
  localparam int PRM_W   = 12;
  localparam int ARG_W   = 14;
  localparam logic [PRM_W-1:0] PARAM_MAX = 12'd4095;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_CSI    = 2'd2;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] FIN_UP   = 8'h41;
  localparam logic [7:0] FIN_DOWN = 8'h42;
  localparam logic [7:0] FIN_RGHT = 8'h43;
  localparam logic [7:0] FIN_LEFT = 8'h44;
  localparam logic [7:0] FIN_POS  = 8'h48;
  localparam logic [7:0] FIN_POSF = 8'h66;
  localparam logic [7:0] FIN_ED   = 8'h4a;
  localparam logic [7:0] FIN_EL   = 8'h4b;
  localparam logic [PRM_W-1:0] ED_ALL = 12'd2;
  localparam logic [2:0] TAB_STOP = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_DONE
  } state_t;

  // Address of column 0 of a screen row, given the ring offset of the top row.
  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, row} + {1'b0, top};
    if (s >= (ROW_W+1)'(ROWS)) s = s - (ROW_W+1)'(ROWS);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(COLS));
  endfunction

endpackage

FILE: src/vt100_lite_text_grid_top.sv
// Text grid terminal: byte parser, cursor and character memory.
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+--------------------
//  request | in_op, in_data_byte, in_read_row, in_read_col      | start high, busy low
//  result  | out_cell_char, out_cursor_row, out_cursor_col      | out_valid, one cycle
//
// Plain and escape bytes answer in the cycle after the request; a read passes
// through ST_READ, a line feed through ST_DONE, a glyph or tab through ST_EMIT and ST_DONE, with a pending wrap first.
// A scroll adds one memory write per cell of the new bottom row; erase to end of line
// sweeps from the cursor column to the row end, and erase of the screen sweeps all CELLS.
// Reset starts a clearing pass over all CELLS (2000) cells with busy held high.
// The receiver cannot stall: each result shows for exactly one cycle.
module vt100_lite_text_grid_top
  import vtg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_op,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  output logic       out_valid,
  output logic [6:0] out_cell_char,
  output logic [4:0] out_cursor_row,
  output logic [6:0] out_cursor_col
);

  // Character memory, rows held as a ring: top_r gives the physical top row.
  logic [6:0] mem [CELLS];
  logic [6:0] rdata_r;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt, top_r, top_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [PRM_W-1:0]  p1_r, p1_nxt, p2_r, p2_nxt;
  logic              p1_seen_r, p1_seen_nxt, p2_seen_r, p2_seen_nxt, in2_r, in2_nxt;
  logic [2:0]        emit_cnt_r, emit_cnt_nxt;
  logic [6:0]        emit_ch_r, emit_ch_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt, clr_last_r, clr_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_char_r, out_char_nxt;

  logic              we_c;
  logic [ADDR_W-1:0] waddr_c, raddr_c;
  logic [6:0]        wdata_c;
  logic              lf_req;
  state_t            lf_ret;
  logic              fin;
  logic [ADDR_W-1:0] cur_base, top_base;
  logic [ARG_W-1:0]  n_arg, r_arg, c_arg, sum_row, sum_col;

  // Append one decimal digit, saturating.
  function automatic logic [PRM_W-1:0] add_digit(input logic [PRM_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [PRM_W+4:0] v;
    v = (PRM_W+5)'(acc) * (PRM_W+5)'(10) + (PRM_W+5)'(d);
    return (v > (PRM_W+5)'(PARAM_MAX)) ? PARAM_MAX : v[PRM_W-1:0];
  endfunction

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cursor_row = 5'(row_r);
  assign out_cursor_col = col_r[6:0];

  assign cur_base = row_base(row_r, top_r);
  assign top_base = ADDR_W'(ADDR_W'(top_r) * ADDR_W'(COLS));

  // Operands of the cursor arithmetic for a control sequence final.
  assign n_arg   = p1_seen_r ? ARG_W'(p1_r) : ARG_W'(1);
  assign r_arg   = (n_arg == '0) ? '0 : n_arg - ARG_W'(1);
  assign c_arg   = p2_seen_r ? ((p2_r == '0) ? '0 : ARG_W'(p2_r) - ARG_W'(1)) : '0;
  assign sum_row = ARG_W'(row_r) + n_arg;
  assign sum_col = ARG_W'(col_r) + n_arg;

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    rdata_r <= mem[raddr_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_IDLE;
      clr_addr_r  <= '0;
      clr_last_r  <= ADDR_W'(CELLS - 1);
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      phase_r     <= PH_NORMAL;
      p1_r        <= '0;
      p2_r        <= '0;
      p1_seen_r   <= 1'b0;
      p2_seen_r   <= 1'b0;
      in2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_last_r  <= clr_last_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      phase_r     <= phase_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      p1_seen_r   <= p1_seen_nxt;
      p2_seen_r   <= p2_seen_nxt;
      in2_r       <= in2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    emit_cnt_r <= emit_cnt_nxt;
    emit_ch_r  <= emit_ch_nxt;
    out_char_r <= out_char_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    clr_addr_nxt  = clr_addr_r;
    clr_last_nxt  = clr_last_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    phase_nxt     = phase_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    p1_seen_nxt   = p1_seen_r;
    p2_seen_nxt   = p2_seen_r;
    in2_nxt       = in2_r;
    emit_cnt_nxt  = emit_cnt_r;
    emit_ch_nxt   = emit_ch_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    we_c          = 1'b0;
    waddr_c       = cur_base + ADDR_W'(col_r);
    wdata_c       = emit_ch_r;
    raddr_c       = row_base(ROW_W'(in_read_row), top_r) + ADDR_W'(in_read_col);
    lf_req        = 1'b0;
    lf_ret        = ST_DONE;
    fin           = 1'b1;

    case (state_r)
      ST_CLEAR: begin
        // Sweep spaces over the range, one cell a cycle.
        we_c    = 1'b1;
        waddr_c = clr_addr_r;
        wdata_c = CH_SPACE[6:0];
        if (clr_addr_r == clr_last_r) begin
          state_nxt = ret_r;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          out_char_nxt = '0;
          if (in_op) begin
            if (32'(in_read_row) < ROWS && 32'(in_read_col) < COLS) begin
              fin       = 1'b0;
              state_nxt = ST_READ;
            end
          end else begin
            case (phase_r)
              PH_ESC: begin
                p1_nxt      = '0;
                p2_nxt      = '0;
                p1_seen_nxt = 1'b0;
                p2_seen_nxt = 1'b0;
                in2_nxt     = 1'b0;
                phase_nxt   = (in_data_byte == CH_LBRK) ? PH_CSI : PH_NORMAL;
              end
              PH_CSI: begin
                if (in_data_byte >= CH_ZERO && in_data_byte <= CH_NINE) begin
                  if (in2_r) begin
                    p2_nxt      = add_digit(p2_r, in_data_byte[3:0]);
                    p2_seen_nxt = 1'b1;
                  end else begin
                    p1_nxt      = add_digit(p1_r, in_data_byte[3:0]);
                    p1_seen_nxt = 1'b1;
                  end
                end else if (in_data_byte == CH_SEMI) begin
                  in2_nxt = 1'b1;
                end else begin
                  case (in_data_byte)
                    FIN_UP: begin
                      row_nxt = (ARG_W'(row_r) > n_arg) ? row_r - ROW_W'(n_arg) : '0;
                    end
                    FIN_DOWN: begin
                      row_nxt = (sum_row >= ARG_W'(ROWS)) ? ROW_W'(ROWS - 1)
                                                          : ROW_W'(sum_row);
                    end
                    FIN_RGHT: begin
                      col_nxt = (sum_col >= ARG_W'(COLS)) ? COL_W'(COLS - 1)
                                                          : COL_W'(sum_col);
                    end
                    FIN_LEFT: begin
                      col_nxt = (ARG_W'(col_r) > n_arg) ? col_r - COL_W'(n_arg) : '0;
                    end
                    FIN_POS, FIN_POSF: begin
                      row_nxt = (r_arg >= ARG_W'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(r_arg);
                      col_nxt = (c_arg >= ARG_W'(COLS)) ? COL_W'(COLS - 1) : COL_W'(c_arg);
                    end
                    FIN_ED: begin
                      if (p1_seen_r && p1_r == ED_ALL) begin
                        fin          = 1'b0;
                        clr_addr_nxt = '0;
                        clr_last_nxt = ADDR_W'(CELLS - 1);
                        ret_nxt      = ST_DONE;
                        state_nxt    = ST_CLEAR;
                      end
                    end
                    FIN_EL: begin
                      // Nothing to erase while a wrap is pending.
                      if (32'(col_r) < COLS) begin
                        fin          = 1'b0;
                        clr_addr_nxt = cur_base + ADDR_W'(col_r);
                        clr_last_nxt = cur_base + ADDR_W'(COLS - 1);
                        ret_nxt      = ST_DONE;
                        state_nxt    = ST_CLEAR;
                      end
                    end
                    default: begin
                    end
                  endcase
                  p1_nxt      = '0;
                  p2_nxt      = '0;
                  p1_seen_nxt = 1'b0;
                  p2_seen_nxt = 1'b0;
                  in2_nxt     = 1'b0;
                  phase_nxt   = PH_NORMAL;
                end
              end
              default: begin
                phase_nxt = PH_NORMAL;
                if (in_data_byte == CH_ESC) begin
                  phase_nxt = PH_ESC;
                end else if (in_data_byte == CH_CR) begin
                  col_nxt = '0;
                end else if (in_data_byte == CH_LF) begin
                  fin    = 1'b0;
                  lf_req = 1'b1;
                  lf_ret = ST_DONE;
                end else if (in_data_byte == CH_BS) begin
                  if (col_r != '0) col_nxt = col_r - COL_W'(1);
                end else if (in_data_byte == CH_BEL) begin
                  col_nxt = col_r;
                end else if (in_data_byte == CH_TAB) begin
                  fin          = 1'b0;
                  emit_cnt_nxt = TAB_STOP - {1'b0, col_r[1:0]};
                  emit_ch_nxt  = CH_SPACE[6:0];
                  state_nxt    = ST_EMIT;
                end else if (in_data_byte >= CH_SPACE && in_data_byte < CH_DEL) begin
                  fin          = 1'b0;
                  emit_cnt_nxt = 3'd1;
                  emit_ch_nxt  = in_data_byte[6:0];
                  state_nxt    = ST_EMIT;
                end
              end
            endcase
          end
          out_valid_nxt = fin;
        end
      end

      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rdata_r;
        state_nxt     = ST_IDLE;
      end

      ST_EMIT: begin
        if (32'(col_r) >= COLS) begin
          // Wrap first, then come back to print.
          lf_req = 1'b1;
          lf_ret = ST_EMIT;
        end else begin
          we_c         = 1'b1;
          col_nxt      = col_r + COL_W'(1);
          emit_cnt_nxt = emit_cnt_r - 3'd1;
          if (emit_cnt_r == 3'd1) state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = '0;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Line feed: advance the row, or rotate the ring and blank the old top row.
    if (lf_req) begin
      col_nxt = '0;
      if (row_r == ROW_W'(ROWS - 1)) begin
        top_nxt      = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
        clr_addr_nxt = top_base;
        clr_last_nxt = top_base + ADDR_W'(COLS - 1);
        ret_nxt      = lf_ret;
        state_nxt    = ST_CLEAR;
      end else begin
        row_nxt   = row_r + ROW_W'(1);
        state_nxt = lf_ret;
      end
    end
  end

endmodule

FILE: src/vtg_checker.sv
// Port-level checker of the text grid terminal and its bind.
`include "vt100_lite_text_grid_top_macros.svh"

module vtg_checker
  import vtg_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [4:0] out_cursor_row,
  input logic [6:0] out_cursor_col
);

  // Reset starts the clearing pass: busy, no result.
  `VTG_ASSERT_RST(a_reset_clears, (!rst_n) |=> (busy && !out_valid), "reset must start clearing")
  // An accepted request either answers at once or keeps the block busy.
  `VTG_ASSERT(a_accept_progress, (start && !busy) |=> (busy || out_valid), "request lost")
  // A result only shows once work has finished.
  `VTG_ASSERT(a_result_idle, out_valid |-> !busy, "result while busy")
  // The reported cursor stays on the grid, or one past the last column.
  `VTG_ASSERT(a_cursor_range,
    out_valid |-> (32'(out_cursor_row) < ROWS && 32'(out_cursor_col) <= COLS),
    "cursor off grid")

endmodule

bind vt100_lite_text_grid_top vtg_checker u_vtg_checker (.*);

FILE: tb/tb_vt100_lite_text_grid_top.sv
// Self-checking testbench of the text grid terminal, with its scoreboard class.
`timescale 1ns / 100ps

typedef struct packed {
  logic [6:0] cell_char;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
} grid_answer_t;

// Tracks the screen, cursor and parser state and the answers still owed.
class text_grid_board;
  logic [6:0]   cells[vtg_pkg::CELLS];
  int           row, col;
  logic [1:0]   phase;
  int           prm_a, prm_b;
  bit           seen_a, seen_b, on_b;
  grid_answer_t owed[$];
  int           errors;

  function new();
    foreach (cells[i]) cells[i] = 7'h20;
    row = 0;
    col = 0;
    phase = vtg_pkg::PH_NORMAL;
    drop_params();
    errors = 0;
  endfunction

  function void drop_params();
    prm_a = 0;
    prm_b = 0;
    seen_a = 0;
    seen_b = 0;
    on_b = 0;
  endfunction

  function void next_line();
    col = 0;
    row++;
    if (row >= vtg_pkg::ROWS) begin
      for (int i = 0; i < (vtg_pkg::ROWS - 1) * vtg_pkg::COLS; i++)
        cells[i] = cells[i + vtg_pkg::COLS];
      for (int i = (vtg_pkg::ROWS - 1) * vtg_pkg::COLS; i < vtg_pkg::CELLS; i++)
        cells[i] = 7'h20;
      row = vtg_pkg::ROWS - 1;
    end
  endfunction

  function void print_cell(logic [7:0] ch);
    if (col >= vtg_pkg::COLS) next_line();
    cells[row * vtg_pkg::COLS + col] = ch[6:0];
    col++;
  endfunction

  function int add_digit(int acc, int d);
    int v;
    v = acc * 10 + d;
    return (v > 4095) ? 4095 : v;
  endfunction

  function void run_final(logic [7:0] b);
    int n, r, c;
    n = seen_a ? prm_a : 1;
    case (b)
      vtg_pkg::FIN_UP:   row = (row > n) ? row - n : 0;
      vtg_pkg::FIN_DOWN: row = (row + n >= vtg_pkg::ROWS) ? vtg_pkg::ROWS - 1 : row + n;
      vtg_pkg::FIN_RGHT: col = (col + n >= vtg_pkg::COLS) ? vtg_pkg::COLS - 1 : col + n;
      vtg_pkg::FIN_LEFT: col = (col > n) ? col - n : 0;
      vtg_pkg::FIN_POS, vtg_pkg::FIN_POSF: begin
        r = seen_a ? prm_a : 1;
        c = seen_b ? prm_b : 1;
        r = (r > 0) ? r - 1 : 0;
        c = (c > 0) ? c - 1 : 0;
        row = (r >= vtg_pkg::ROWS) ? vtg_pkg::ROWS - 1 : r;
        col = (c >= vtg_pkg::COLS) ? vtg_pkg::COLS - 1 : c;
      end
      vtg_pkg::FIN_ED: begin
        if (seen_a && prm_a == 2) foreach (cells[i]) cells[i] = 7'h20;
      end
      vtg_pkg::FIN_EL: begin
        for (int i = col; i < vtg_pkg::COLS; i++) cells[row * vtg_pkg::COLS + i] = 7'h20;
      end
      default: ;
    endcase
  endfunction

  function void take_byte(logic [7:0] b);
    int n;
    if (phase == vtg_pkg::PH_ESC) begin
      drop_params();
      phase = (b == vtg_pkg::CH_LBRK) ? vtg_pkg::PH_CSI : vtg_pkg::PH_NORMAL;
      return;
    end
    if (phase == vtg_pkg::PH_CSI) begin
      if (b >= vtg_pkg::CH_ZERO && b <= vtg_pkg::CH_NINE) begin
        if (on_b) begin
          prm_b = add_digit(prm_b, b - vtg_pkg::CH_ZERO);
          seen_b = 1;
        end else begin
          prm_a = add_digit(prm_a, b - vtg_pkg::CH_ZERO);
          seen_a = 1;
        end
        return;
      end
      if (b == vtg_pkg::CH_SEMI) begin
        on_b = 1;
        return;
      end
      run_final(b);
      drop_params();
      phase = vtg_pkg::PH_NORMAL;
      return;
    end
    phase = vtg_pkg::PH_NORMAL;
    case (b)
      vtg_pkg::CH_ESC: phase = vtg_pkg::PH_ESC;
      vtg_pkg::CH_CR:  col = 0;
      vtg_pkg::CH_LF:  next_line();
      vtg_pkg::CH_BS:  if (col > 0) col--;
      vtg_pkg::CH_BEL: ;
      vtg_pkg::CH_TAB: begin
        n = 4 - (col & 3);
        repeat (n) print_cell(vtg_pkg::CH_SPACE);
      end
      default: if (b >= vtg_pkg::CH_SPACE && b < vtg_pkg::CH_DEL) print_cell(b);
    endcase
  endfunction

  // Note an accepted request and queue the answer it must produce.
  function void note_request(logic op, logic [7:0] b, logic [4:0] rr, logic [6:0] rc);
    grid_answer_t a;
    a.cell_char = 7'd0;
    if (op == 1'b0) take_byte(b);
    else if (rr < vtg_pkg::ROWS && rc < vtg_pkg::COLS)
      a.cell_char = cells[rr * vtg_pkg::COLS + rc];
    a.cursor_row = row[4:0];
    a.cursor_col = col[6:0];
    owed.push_back(a);
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task check_answer(logic [6:0] ch, logic [4:0] r, logic [6:0] c);
    grid_answer_t a;
    if (owed.size() == 0) begin
      report($sformatf("unexpected answer char=%0h row=%0d col=%0d", ch, r, c));
      return;
    end
    a = owed.pop_front();
    if (ch !== a.cell_char)
      report($sformatf("cell_char got %0h want %0h", ch, a.cell_char));
    if (r !== a.cursor_row)
      report($sformatf("cursor_row got %0d want %0d", r, a.cursor_row));
    if (c !== a.cursor_col)
      report($sformatf("cursor_col got %0d want %0d", c, a.cursor_col));
  endtask
endclass

module tb_vt100_lite_text_grid_top;
  import vtg_pkg::*;

  localparam int STALL_LIMIT = 30000;  // covers the reset clearing pass and a full erase

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_op;
  logic [7:0] in_data_byte;
  logic [4:0] in_read_row;
  logic [6:0] in_read_col;
  logic       out_valid;
  logic [6:0] out_cell_char;
  logic [4:0] out_cursor_row;
  logic [6:0] out_cursor_col;

  text_grid_board board;
  int gap_pct;     // chance in a hundred that the sender idles before a request
  int sent;        // requests accepted so far
  int quiet = 0;   // cycles with nothing accepted on either side

  vt100_lite_text_grid_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_data_byte  (in_data_byte),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_cell_char (out_cell_char),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Check answers first, then note the request taken at the same edge, so the
  // queue order always matches the order in which the block works.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid || (start && !busy)) quiet <= 0;
      else quiet <= quiet + 1;
      if (out_valid) begin
        board.check_answer(out_cell_char, out_cursor_row, out_cursor_col);
      end
      if (start && !busy) begin
        board.note_request(in_op, in_data_byte, in_read_row, in_read_col);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL vt100_lite_text_grid_top");
      $finish;
    end
  end

  // Drive one request and hold it until the block takes it. Start stays high
  // afterwards so back-to-back requests need no idle gap.
  task send_req(logic op, logic [7:0] b, logic [4:0] rr, logic [6:0] rc);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    in_read_row  <= rr;
    in_read_col  <= rc;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task feed(logic [7:0] b);
    send_req(1'b0, b, 5'($urandom), 7'($urandom));
  endtask

  task peek(logic [4:0] rr, logic [6:0] rc);
    send_req(1'b1, 8'($urandom), rr, rc);
  endtask

  task feed_number(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  // Send ESC [ with optional parameters and the given final byte.
  task feed_csi(bit has_a, int a, bit has_b, int b, int semis, logic [7:0] fin);
    feed(CH_ESC);
    feed(CH_LBRK);
    if (has_a) feed_number(a);
    repeat (semis) feed(CH_SEMI);
    if (has_b) feed_number(b);
    feed(fin);
  endtask

  // Hold the sender until every answer owed has arrived.
  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function int pick_param();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(0, 30);
    if (k < 95) return $urandom_range(0, 99);
    return $urandom_range(0, 99999);
  endfunction

  task random_sequence();
    int k;
    logic [7:0] fin;
    k = $urandom_range(99);
    if (k < 30) begin
      // run of glyphs, long enough now and then to wrap
      repeat ($urandom_range(1, 12)) feed(8'($urandom_range(CH_SPACE, CH_DEL - 1)));
    end else if (k < 45) begin
      if ($urandom_range(3) == 0) peek(5'($urandom), 7'($urandom));
      else peek(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
    end else if (k < 75) begin
      case ($urandom_range(10))
        0: fin = FIN_UP;
        1: fin = FIN_DOWN;
        2: fin = FIN_RGHT;
        3: fin = FIN_LEFT;
        4: fin = FIN_POS;
        5: fin = FIN_POSF;
        6: fin = FIN_ED;
        7: fin = FIN_EL;
        8: fin = "m";
        9: fin = CH_ESC;
        default: fin = 8'($urandom);
      endcase
      if (fin == FIN_ED && $urandom_range(3) == 0)
        feed_csi(1, 2, 0, 0, 0, fin);
      else if (fin == FIN_ED)
        feed_csi($urandom_range(1), $urandom_range(0, 1), 0, 0, 0, fin);
      else
        feed_csi($urandom_range(3) != 0, pick_param(), $urandom_range(1),
                 pick_param(), $urandom_range(0, 2), fin);
    end else if (k < 90) begin
      case ($urandom_range(5))
        0: feed(CH_CR);
        1: feed(CH_LF);
        2: feed(CH_BS);
        3: feed(CH_BEL);
        4: feed(CH_TAB);
        default: begin
          feed(CH_ESC);
          feed(8'($urandom));
        end
      endcase
    end else begin
      feed(8'($urandom));
    end
  endtask

  initial begin
    int phase_gap[4];
    board        = new();
    phase_gap    = '{0, 52, 25, 0};
    gap_pct      = 0;
    sent         = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = 1'b0;
    in_data_byte = 8'd0;
    in_read_row  = 5'd0;
    in_read_col  = 7'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, out-of-range reads, each control byte and sequence.
    peek(5'd0, 7'd0);
    peek(5'd24, 7'd79);
    peek(5'd31, 7'd127);
    peek(5'd25, 7'd0);
    feed(8'h7e);
    feed(CH_DEL);
    feed(8'hff);
    feed(CH_TAB);
    feed(CH_BS);
    feed(CH_BEL);
    feed(CH_CR);
    feed(CH_ESC);
    feed("x");
    feed_csi(1, 99999, 1, 5, 3, FIN_POS);    // saturated row, extra semicolons
    feed_csi(0, 0, 0, 0, 0, FIN_RGHT);
    feed_csi(1, 0, 1, 80, 1, FIN_POSF);      // zero row acts as one
    feed("A");
    feed("B");                               // wraps first, then prints on the next row
    feed_csi(0, 0, 0, 0, 0, FIN_EL);         // erases the rest of the new row
    feed_csi(1, 3, 0, 0, 0, FIN_LEFT);
    feed_csi(1, 40, 0, 0, 0, FIN_DOWN);
    feed(CH_LF);                             // scroll from the bottom row
    feed_csi(1, 9, 0, 0, 0, FIN_UP);
    feed_csi(0, 0, 0, 0, 0, FIN_EL);
    feed_csi(1, 1, 0, 0, 0, "m");
    feed(CH_ESC);
    feed(CH_LBRK);
    feed(CH_ESC);                            // ESC as an unknown final
    feed_csi(1, 2, 0, 0, 0, FIN_ED);
    peek(5'd0, 7'd0);
    drain();

    // Random phases with different sender idling; drain between phases.
    for (int p = 0; p < 4; p++) begin
      gap_pct = phase_gap[p];
      while (sent < 30 + (p + 1) * 160) random_sequence();
      drain();
    end

    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("PASS vt100_lite_text_grid_top");
    end else begin
      $display("FAIL vt100_lite_text_grid_top");
    end
    $finish;
  end
endmodule

FILE: vt100_lite_text_grid_top.f
+incdir+src
src/vtg_pkg.sv
src/vt100_lite_text_grid_top.sv
src/vtg_checker.sv
tb/tb_vt100_lite_text_grid_top.sv
